// ===== src/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  localparam int SYM_W       = 8;
  localparam int CODE_W      = 32;
  localparam int LEN_W       = 6;
  localparam int PEND_W      = 7;
  localparam int CNT_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int PADV_W      = 4;
  localparam int ACC_W       = CODE_W + PEND_W;
  localparam int TOTAL_W     = 6;
  localparam int NB_W        = 3;
  localparam int TABLE_DEPTH = 256;
  localparam int ENTRY_W     = CODE_W + LEN_W;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

endpackage

// ===== src/hcbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/huffman_code_bit_packer_top.sv =====
// Top level of the Huffman code bit packer: code table, bit accumulator and byte emitter.
//
// Loads (cmd 0) write code and capped length into the symbol's entry of a 256-entry table
// RAM at the transfer. An encode (cmd 1) reads the table, waits in stage 1 for the
// registered read data, then appends the code to the pending bits and hands the
// complete bytes to the emitter; a flush (cmd 2) hands over the padded byte, if bits are
// pending, and the padding count. The emitter sends one byte per cycle while out_ready is
// high; an encode yields at most four bytes and a flush at most two outputs, and a new
// item is taken while the last output of the previous one is being sent. Table lengths
// read as zero after reset through a per-entry valid flag; no clearing pass is needed.
module huffman_code_bit_packer_top
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_len,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_is_pad_count,
  output logic              out_last
);

  localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);

  logic                   in_fire;
  logic [LEN_W-1:0]       load_len;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [TABLE_DEPTH-1:0] entry_vld_r;

  logic                   s1_v_r;
  cmd_t                   s1_cmd_r;
  logic                   s1_hit_r;
  logic                   s1_go;

  logic [PEND_W-1:0]      pend_r, pend_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic [CODE_W-1:0]      em_data_r, em_data_nxt;
  logic [NB_W-1:0]        em_nd_r, em_nd_nxt;
  logic                   em_pad_r, em_pad_nxt;
  logic [PADV_W-1:0]      em_padv_r, em_padv_nxt;
  logic                   em_take;

  logic [CODE_W-1:0]      r_code;
  logic [LEN_W-1:0]       r_len;
  logic [CODE_W:0]        code_mask;
  logic [CODE_W-1:0]      code_m;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       acc_sh;
  logic [TOTAL_W-1:0]     total;
  logic [CNT_W-1:0]       rem;
  logic [BYTE_W-1:0]      keep_mask;
  logic [BYTE_W-1:0]      flush_byte;
  logic [1:0]             byte_sel;

  assign in_fire  = in_valid && in_ready;
  assign load_len = (in_code_len > LEN_CAP_V) ? LEN_CAP_V : in_code_len;

  hcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (in_fire && (in_cmd == CMD_LOAD)),
    .waddr(in_symbol),
    .wdata({load_len, in_code_bits}),
    .re   (in_fire),
    .raddr(in_symbol),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
    end else if (in_fire && (in_cmd == CMD_LOAD)) begin
      entry_vld_r[in_symbol] <= 1'b1;
    end
  end

  // Stage 1: hold the command while its table read completes.
  assign em_take  = !out_valid || (out_ready && out_last);
  assign s1_go    = s1_v_r && em_take;
  assign in_ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= cmd_t'(in_cmd);
      s1_hit_r <= entry_vld_r[in_symbol];
    end
  end

  // Stage 2: merge the code into the pending bits.
  assign r_code     = ram_rdata[CODE_W-1:0];
  assign r_len      = s1_hit_r ? ram_rdata[CODE_W +: LEN_W] : '0;
  assign code_mask  = ((CODE_W + 1)'(1) << r_len) - (CODE_W + 1)'(1);
  assign code_m     = r_code & code_mask[CODE_W-1:0];
  assign acc        = ({{(ACC_W - PEND_W){1'b0}}, pend_r} << r_len) |
                      {{(ACC_W - CODE_W){1'b0}}, code_m};
  assign total      = TOTAL_W'(cnt_r) + TOTAL_W'(r_len);
  assign rem        = total[CNT_W-1:0];
  assign acc_sh     = acc >> rem;
  assign keep_mask  = (BYTE_W'(1) << rem) - BYTE_W'(1);
  assign flush_byte = BYTE_W'({1'b0, pend_r} << (PADV_W'(BYTE_W) - PADV_W'(cnt_r)));

  always_comb begin
    pend_nxt    = pend_r;
    cnt_nxt     = cnt_r;
    em_data_nxt = em_data_r;
    em_nd_nxt   = em_nd_r;
    em_pad_nxt  = em_pad_r;
    em_padv_nxt = em_padv_r;
    if (out_valid && out_ready) begin
      if (em_nd_r != '0) begin
        em_nd_nxt = em_nd_r - NB_W'(1);
      end else begin
        em_pad_nxt = 1'b0;
      end
    end
    if (s1_go) begin
      unique case (s1_cmd_r)
        CMD_ENCODE: begin
          if (r_len != '0) begin
            pend_nxt    = acc[PEND_W-1:0] & keep_mask[PEND_W-1:0];
            cnt_nxt     = rem;
            em_data_nxt = acc_sh[CODE_W-1:0];
            em_nd_nxt   = total[TOTAL_W-1:CNT_W];
            em_pad_nxt  = 1'b0;
          end
        end
        CMD_FLUSH: begin
          em_data_nxt = {{(CODE_W - BYTE_W){1'b0}}, flush_byte};
          em_nd_nxt   = (cnt_r != '0) ? NB_W'(1) : '0;
          em_pad_nxt  = 1'b1;
          em_padv_nxt = PADV_W'(BYTE_W) - PADV_W'(cnt_r);
          pend_nxt    = '0;
          cnt_nxt     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      cnt_r    <= '0;
      em_nd_r  <= '0;
      em_pad_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
      em_nd_r  <= em_nd_nxt;
      em_pad_r <= em_pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_data_r <= em_data_nxt;
    em_padv_r <= em_padv_nxt;
  end

  // Emitter: data bytes from the top down, then the padding count.
  assign byte_sel = 2'(em_nd_r - NB_W'(1));

  always_comb begin
    out_byte = {{(BYTE_W - PADV_W){1'b0}}, em_padv_r};
    if (em_nd_r != '0) begin
      unique case (byte_sel)
        2'd0:    out_byte = em_data_r[7:0];
        2'd1:    out_byte = em_data_r[15:8];
        2'd2:    out_byte = em_data_r[23:16];
        default: out_byte = em_data_r[31:24];
      endcase
    end
  end

  assign out_valid        = (em_nd_r != '0) || em_pad_r;
  assign out_is_pad_count = (em_nd_r == '0);
  assign out_last         = ((em_nd_r == NB_W'(1)) && !em_pad_r) ||
                            ((em_nd_r == '0) && em_pad_r);

  ap_pad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_pad_count |-> out_last)
    else $error("padding count not marked last");

  ap_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r >> cnt_r) == '0)
    else $error("stray bits above pending count");

  ap_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    em_nd_r <= NB_W'(4))
    else $error("emitter byte count out of range");

  ap_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !out_last |=> out_valid && !s1_go)
    else $error("new item loaded before emitter drained");

endmodule
